// ===== hdl/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for the running correlation block
// Holds the sequencer states, the divide/root unit control and fixed sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

	// accumulator limits
	localparam int unsigned MAX_SAMPLES = 131071;
	localparam int CNT_W = 17;

	// divide/root unit sizes
	localparam int DSU_A_W   = 64;
	localparam int DSU_D_W   = 48;
	localparam int DSU_ALU_W = 50;
	localparam int DSU_RT_W  = 32;
	localparam int DSU_IT_W  = 7;
	localparam logic [DSU_IT_W-1:0] DIV_STEPS  = DSU_IT_W'(DSU_A_W);
	localparam logic [DSU_IT_W-1:0] SQRT_STEPS = DSU_IT_W'(DSU_A_W / 2);

	// result constants
	localparam logic [14:0] THRESH_RESET = 15'd502;
	localparam logic [14:0] T_SAT        = 15'd32767;
	localparam logic [14:0] R_ONE        = 15'd16384;
	localparam logic [63:0] T2_SAT       = 64'd1073676289;

	typedef enum logic {
		DSU_DIV,
		DSU_SQRT
	} dsu_op_t;

	typedef struct packed {
		logic    start;
		dsu_op_t op;
	} dsu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dsu_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_SUM,
		ST_SQX,
		ST_SQY,
		ST_XY,
		ST_MX,
		ST_MY,
		ST_EX2,
		ST_EY2,
		ST_EXY,
		ST_VX,
		ST_VY,
		ST_CV,
		ST_SDX,
		ST_SDY,
		ST_SDP,
		ST_R,
		ST_RR,
		ST_RN,
		ST_T2,
		ST_TS,
		ST_FIN
	} seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/rpc_dsu.sv =====
// ----------------------------------------------------------------------------
// rpc_dsu: shared divide / square root unit
// Restoring divide (one quotient bit per cycle) and restoring integer root
// (one root bit per cycle) on one compare-subtract datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_dsu (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rpc_pkg::dsu_ctl_t                      ctl,
	input  logic [rpc_pkg::DSU_A_W-1:0]            opa,
	input  logic [rpc_pkg::DSU_D_W-1:0]            opd,
	output rpc_pkg::dsu_sts_t                      sts,
	output logic [rpc_pkg::DSU_A_W-1:0]            result
);

	logic                              busy_q;
	logic                              done_q;
	logic [rpc_pkg::DSU_IT_W-1:0]      iter_q;
	rpc_pkg::dsu_op_t                  op_q;
	logic [rpc_pkg::DSU_A_W-1:0]       a_q;
	logic [rpc_pkg::DSU_D_W-1:0]       d_q;
	logic [rpc_pkg::DSU_ALU_W-1:0]     rem_q;
	logic [rpc_pkg::DSU_RT_W-1:0]      root_q;

	logic [rpc_pkg::DSU_ALU_W-1:0]     minu;
	logic [rpc_pkg::DSU_ALU_W-1:0]     subt;
	logic [rpc_pkg::DSU_ALU_W-1:0]     diff;
	logic [rpc_pkg::DSU_ALU_W-1:0]     nxt_rem;
	logic                              take;

	// shared trial subtract
	always_comb begin
		if (op_q == rpc_pkg::DSU_SQRT) begin
			minu = {14'd0, rem_q[33:0], a_q[63:62]};
			subt = {16'd0, root_q, 2'b01};
		end else begin
			minu = {rem_q[48:0], a_q[63]};
			subt = {2'd0, d_q};
		end
		take    = (minu >= subt);
		diff    = minu - subt;
		nxt_rem = take ? diff : minu;
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				iter_q <= (ctl.op == rpc_pkg::DSU_SQRT) ? rpc_pkg::SQRT_STEPS
					: rpc_pkg::DIV_STEPS;
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand / partial result registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q   <= ctl.op;
			a_q    <= opa;
			d_q    <= opd;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q <= nxt_rem;
			if (op_q == rpc_pkg::DSU_SQRT) begin
				a_q    <= {a_q[61:0], 2'b00};
				root_q <= {root_q[30:0], take};
			end else begin
				a_q <= {a_q[62:0], take};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = (op_q == rpc_pkg::DSU_SQRT) ? {32'd0, root_q} : a_q;

endmodule

`default_nettype wire

// ===== hdl/running_pearson_correlation.sv =====
// ----------------------------------------------------------------------------
// running_pearson_correlation: running mean, deviation, Pearson r and t
// Accumulates (x, y) pairs and computes the statistics of each item with a
// small sequencer, one shared multiplier and one shared divide/root unit.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  input    | in_valid / in_stall | command, x_sample, y_sample
//  output   | out_valid/out_stall | sample_count .. significant
//  config   | cfg_we              | cfg_wdata (significance threshold)
//
//  An item runs seven divides and three roots on the shared divide/root unit
//  between its sequencer steps. Invalid statistics skip the r and t steps;
//  |r| at one skips the t steps.
//  Reset clears the count, all sums and sets the threshold to 502.
//  in_stall is high while an item is in work; a result waiting on out_stall
//  does not block the next item until its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module running_pearson_correlation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic signed [15:0] x_sample,
	input  logic signed [15:0] y_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        sample_count,
	output logic signed [15:0] mean_x,
	output logic signed [15:0] mean_y,
	output logic [14:0]        deviation_x,
	output logic [14:0]        deviation_y,
	output logic signed [15:0] correlation,
	output logic signed [15:0] t_value,
	output logic               stats_valid,
	output logic               significant
);

	localparam logic [16:0] MAX_CNT = 17'(rpc_pkg::MAX_SAMPLES);

	rpc_pkg::seq_state_t state_q, state_nx;
	rpc_pkg::dsu_ctl_t   dsu_ctl;
	rpc_pkg::dsu_sts_t   dsu_sts;
	logic [63:0]         dsu_a;
	logic [47:0]         dsu_d;
	logic [63:0]         dsu_res;
	logic                launched_q;

	// accumulators and config
	logic [14:0]         thr_q;
	logic [16:0]         count_q;
	logic signed [33:0]  sum_x_q, sum_y_q;
	logic [49:0]         sum_x2_q, sum_y2_q;
	logic signed [50:0]  sum_xy_q;
	logic                cmd_q, acc_q;
	logic signed [15:0]  x_q, y_q;

	// per-item intermediates
	logic signed [24:0]  mx_q, my_q;
	logic [46:0]         ex2_q, ey2_q;
	logic signed [47:0]  exy_q;
	logic [46:0]         varx_q, vary_q;
	logic signed [48:0]  cov_q;
	logic [23:0]         sdx_q, sdy_q;
	logic [14:0]         rm_q;
	logic [27:0]         rr_q;
	logic [29:0]         t2_q;
	logic [14:0]         tm_q;

	// shared multiplier
	logic signed [32:0]  mul_a, mul_b;
	logic signed [65:0]  prod_q;

	// output registers
	logic                out_valid_q;
	logic [16:0]         cnt_o_q;
	logic signed [15:0]  mx_o_q, my_o_q, r_o_q, t_o_q;
	logic [14:0]         dx_o_q, dy_o_q;
	logic                valid_o_q, sig_o_q;

	// combinational helpers
	logic [33:0]         mag_sx, mag_sy;
	logic [50:0]         mag_sxy;
	logic [48:0]         cov_mag;
	logic [14:0]         dox, doy;
	logic                stats_ok;
	logic [28:0]         t2_den;
	logic signed [15:0]  mean_x_c, mean_y_c;
	logic                op_done;

	function automatic logic [14:0] round_dev(input logic [23:0] sd);
		logic [24:0] s;
		s = {1'b0, sd} + 25'd128;
		return (s[24:8] > 17'd32767) ? 15'd32767 : s[22:8];
	endfunction

	function automatic logic signed [15:0] round_mean(input logic signed [24:0] m);
		logic [24:0] mag;
		logic [24:0] s;
		mag = m[24] ? 25'(-m) : 25'(m);
		s   = mag + 25'd128;
		if (!m[24]) begin
			return (s[24:8] > 17'd32767) ? 16'sd32767 : 16'(s[24:8]);
		end else begin
			return 16'(-s[24:8]);
		end
	endfunction

	// magnitudes, deviations, validity
	always_comb begin
		mag_sx   = sum_x_q[33] ? 34'(-sum_x_q) : 34'(sum_x_q);
		mag_sy   = sum_y_q[33] ? 34'(-sum_y_q) : 34'(sum_y_q);
		mag_sxy  = sum_xy_q[50] ? 51'(-sum_xy_q) : 51'(sum_xy_q);
		cov_mag  = cov_q[48] ? 49'(-cov_q) : 49'(cov_q);
		dox      = round_dev(sdx_q);
		doy      = round_dev(sdy_q);
		stats_ok = (count_q >= 17'd3) && (dox != 15'd0) && (doy != 15'd0);
		t2_den   = 29'h1000_0000 - {1'b0, rr_q};
		mean_x_c = round_mean(mx_q);
		mean_y_c = round_mean(my_q);
		op_done  = launched_q && dsu_sts.done;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rpc_pkg::ST_IDLE: if (in_valid) state_nx = rpc_pkg::ST_CLR;
			rpc_pkg::ST_CLR:  state_nx = rpc_pkg::ST_SUM;
			rpc_pkg::ST_SUM:  state_nx = rpc_pkg::ST_SQX;
			rpc_pkg::ST_SQX:  state_nx = rpc_pkg::ST_SQY;
			rpc_pkg::ST_SQY:  state_nx = rpc_pkg::ST_XY;
			rpc_pkg::ST_XY:   state_nx = rpc_pkg::ST_MX;
			rpc_pkg::ST_MX:   if (op_done) state_nx = rpc_pkg::ST_MY;
			rpc_pkg::ST_MY:   if (op_done) state_nx = rpc_pkg::ST_EX2;
			rpc_pkg::ST_EX2:  if (op_done) state_nx = rpc_pkg::ST_EY2;
			rpc_pkg::ST_EY2:  if (op_done) state_nx = rpc_pkg::ST_EXY;
			rpc_pkg::ST_EXY:  if (op_done) state_nx = rpc_pkg::ST_VX;
			rpc_pkg::ST_VX:   state_nx = rpc_pkg::ST_VY;
			rpc_pkg::ST_VY:   state_nx = rpc_pkg::ST_CV;
			rpc_pkg::ST_CV:   state_nx = rpc_pkg::ST_SDX;
			rpc_pkg::ST_SDX:  if (op_done) state_nx = rpc_pkg::ST_SDY;
			rpc_pkg::ST_SDY:  if (op_done) state_nx = rpc_pkg::ST_SDP;
			rpc_pkg::ST_SDP:  state_nx = stats_ok ? rpc_pkg::ST_R : rpc_pkg::ST_FIN;
			rpc_pkg::ST_R: begin
				if (op_done) begin
					state_nx = (dsu_res >= 64'(rpc_pkg::R_ONE)) ? rpc_pkg::ST_FIN
						: rpc_pkg::ST_RR;
				end
			end
			rpc_pkg::ST_RR:   state_nx = rpc_pkg::ST_RN;
			rpc_pkg::ST_RN:   state_nx = rpc_pkg::ST_T2;
			rpc_pkg::ST_T2: begin
				if (op_done) begin
					state_nx = (dsu_res >= rpc_pkg::T2_SAT) ? rpc_pkg::ST_FIN
						: rpc_pkg::ST_TS;
				end
			end
			rpc_pkg::ST_TS:   if (op_done) state_nx = rpc_pkg::ST_FIN;
			rpc_pkg::ST_FIN:  if (!out_valid_q || !out_stall) state_nx = rpc_pkg::ST_IDLE;
			default:          state_nx = rpc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: unit operands and multiplier operands
	always_comb begin
		dsu_ctl.start = 1'b0;
		dsu_ctl.op    = rpc_pkg::DSU_DIV;
		dsu_a         = '0;
		dsu_d         = {31'd0, count_q};
		mul_a         = '0;
		mul_b         = '0;
		case (state_q)
			rpc_pkg::ST_SUM: begin
				mul_a = 33'(x_q);
				mul_b = 33'(x_q);
			end
			rpc_pkg::ST_SQX: begin
				mul_a = 33'(y_q);
				mul_b = 33'(y_q);
			end
			rpc_pkg::ST_SQY: begin
				mul_a = 33'(x_q);
				mul_b = 33'(y_q);
			end
			rpc_pkg::ST_MX:  dsu_a = {22'd0, mag_sx[33:0], 8'd0};
			rpc_pkg::ST_MY:  dsu_a = {22'd0, mag_sy[33:0], 8'd0};
			rpc_pkg::ST_EX2: dsu_a = {sum_x2_q[47:0], 16'd0};
			rpc_pkg::ST_EY2: dsu_a = {sum_y2_q[47:0], 16'd0};
			rpc_pkg::ST_EXY: dsu_a = {mag_sxy[47:0], 16'd0};
			rpc_pkg::ST_VX: begin
				mul_a = 33'(mx_q);
				mul_b = 33'(mx_q);
			end
			rpc_pkg::ST_VY: begin
				mul_a = 33'(my_q);
				mul_b = 33'(my_q);
			end
			rpc_pkg::ST_CV: begin
				mul_a = 33'(mx_q);
				mul_b = 33'(my_q);
			end
			rpc_pkg::ST_SDX: begin
				dsu_ctl.op = rpc_pkg::DSU_SQRT;
				dsu_a      = {17'd0, varx_q};
			end
			rpc_pkg::ST_SDY: begin
				dsu_ctl.op = rpc_pkg::DSU_SQRT;
				dsu_a      = {17'd0, vary_q};
			end
			rpc_pkg::ST_SDP: begin
				mul_a = {9'd0, sdx_q};
				mul_b = {9'd0, sdy_q};
			end
			rpc_pkg::ST_R: begin
				dsu_a = {1'b0, cov_mag, 14'd0} + {17'd0, prod_q[47:1]};
				dsu_d = prod_q[47:0];
			end
			rpc_pkg::ST_RR: begin
				mul_a = {18'd0, rm_q};
				mul_b = {18'd0, rm_q};
			end
			rpc_pkg::ST_RN: begin
				mul_a = {5'd0, prod_q[27:0]};
				mul_b = {16'd0, count_q - 17'd2};
			end
			rpc_pkg::ST_T2: begin
				dsu_a = {prod_q[47:0], 16'd0};
				dsu_d = {19'd0, t2_den};
			end
			rpc_pkg::ST_TS: begin
				dsu_ctl.op = rpc_pkg::DSU_SQRT;
				dsu_a      = {34'd0, t2_q};
			end
			default: ;
		endcase
		case (state_q)
			rpc_pkg::ST_MX, rpc_pkg::ST_MY, rpc_pkg::ST_EX2, rpc_pkg::ST_EY2,
			rpc_pkg::ST_EXY, rpc_pkg::ST_SDX, rpc_pkg::ST_SDY, rpc_pkg::ST_R,
			rpc_pkg::ST_T2, rpc_pkg::ST_TS: dsu_ctl.start = !launched_q;
			default: dsu_ctl.start = 1'b0;
		endcase
	end

	rpc_dsu u_dsu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dsu_ctl),
		.opa    (dsu_a),
		.opd    (dsu_d),
		.sts    (dsu_sts),
		.result (dsu_res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpc_pkg::ST_IDLE;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
			thr_q       <= rpc_pkg::THRESH_RESET;
			count_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_x2_q    <= '0;
			sum_y2_q    <= '0;
			sum_xy_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) thr_q <= cfg_wdata;
			if (dsu_ctl.start) launched_q <= 1'b1;
			else if (dsu_sts.done) launched_q <= 1'b0;
			if (state_q == rpc_pkg::ST_FIN && state_nx == rpc_pkg::ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rpc_pkg::ST_CLR: begin
					if (cmd_q) begin
						count_q  <= '0;
						sum_x_q  <= '0;
						sum_y_q  <= '0;
						sum_x2_q <= '0;
						sum_y2_q <= '0;
						sum_xy_q <= '0;
					end
				end
				rpc_pkg::ST_SUM: begin
					if (count_q < MAX_CNT) begin
						count_q <= count_q + 17'd1;
						sum_x_q <= sum_x_q + 34'(x_q);
						sum_y_q <= sum_y_q + 34'(y_q);
					end
				end
				rpc_pkg::ST_SQX: if (acc_q) sum_x2_q <= sum_x2_q + prod_q[49:0];
				rpc_pkg::ST_SQY: if (acc_q) sum_y2_q <= sum_y2_q + prod_q[49:0];
				rpc_pkg::ST_XY:  if (acc_q) sum_xy_q <= sum_xy_q + prod_q[50:0];
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == rpc_pkg::ST_IDLE && in_valid) begin
			cmd_q <= command;
			x_q   <= x_sample;
			y_q   <= y_sample;
		end
		case (state_q)
			rpc_pkg::ST_CLR: begin
				rm_q <= '0;
				tm_q <= '0;
			end
			rpc_pkg::ST_SUM: acc_q <= (count_q < MAX_CNT);
			rpc_pkg::ST_MX: begin
				if (op_done) mx_q <= sum_x_q[33] ? -25'(dsu_res[24:0]) : 25'(dsu_res[24:0]);
			end
			rpc_pkg::ST_MY: begin
				if (op_done) my_q <= sum_y_q[33] ? -25'(dsu_res[24:0]) : 25'(dsu_res[24:0]);
			end
			rpc_pkg::ST_EX2: if (op_done) ex2_q <= dsu_res[46:0];
			rpc_pkg::ST_EY2: if (op_done) ey2_q <= dsu_res[46:0];
			rpc_pkg::ST_EXY: begin
				if (op_done) exy_q <= sum_xy_q[50] ? -48'(dsu_res[47:0]) : 48'(dsu_res[47:0]);
			end
			rpc_pkg::ST_VY: begin
				varx_q <= ({1'b0, ex2_q} > prod_q[47:0]) ? 47'({1'b0, ex2_q} - prod_q[47:0])
					: 47'd0;
			end
			rpc_pkg::ST_CV: begin
				vary_q <= ({1'b0, ey2_q} > prod_q[47:0]) ? 47'({1'b0, ey2_q} - prod_q[47:0])
					: 47'd0;
			end
			rpc_pkg::ST_SDX: begin
				if (!launched_q) cov_q <= {exy_q[47], exy_q} - prod_q[48:0];
				if (op_done) sdx_q <= dsu_res[23:0];
			end
			rpc_pkg::ST_SDY: if (op_done) sdy_q <= dsu_res[23:0];
			rpc_pkg::ST_R: begin
				if (op_done) begin
					if (dsu_res >= 64'(rpc_pkg::R_ONE)) begin
						rm_q <= rpc_pkg::R_ONE;
						tm_q <= rpc_pkg::T_SAT;
					end else begin
						rm_q <= dsu_res[14:0];
					end
				end
			end
			rpc_pkg::ST_RN: rr_q <= prod_q[27:0];
			rpc_pkg::ST_T2: begin
				if (op_done) begin
					if (dsu_res >= rpc_pkg::T2_SAT) tm_q <= rpc_pkg::T_SAT;
					else t2_q <= dsu_res[29:0];
				end
			end
			rpc_pkg::ST_TS: if (op_done) tm_q <= dsu_res[14:0];
			rpc_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cnt_o_q   <= count_q;
					mx_o_q    <= mean_x_c;
					my_o_q    <= mean_y_c;
					dx_o_q    <= dox;
					dy_o_q    <= doy;
					valid_o_q <= stats_ok;
					r_o_q     <= !stats_ok ? 16'sd0
						: (cov_q[48] ? -16'(rm_q) : 16'(rm_q));
					t_o_q     <= !stats_ok ? 16'sd0
						: (cov_q[48] ? -16'(tm_q) : 16'(tm_q));
					sig_o_q   <= stats_ok && (tm_q >= thr_q);
				end
			end
			default: ;
		endcase
	end

	// ports
	assign in_stall     = (state_q != rpc_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign sample_count = cnt_o_q;
	assign mean_x       = mx_o_q;
	assign mean_y       = my_o_q;
	assign deviation_x  = dx_o_q;
	assign deviation_y  = dy_o_q;
	assign correlation  = r_o_q;
	assign t_value      = t_o_q;
	assign stats_valid  = valid_o_q;
	assign significant  = sig_o_q;

`ifndef SYNTHESIS
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpc_pkg::ST_SQX |-> count_q != 17'd0)
		else $error("count is zero after accumulation");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stats_valid |-> correlation == 16'sd0 && t_value == 16'sd0)
		else $error("invalid result carries nonzero r or t");

	a_sig_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && significant |-> stats_valid)
		else $error("significant without valid statistics");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dsu_ctl.start |-> !dsu_sts.busy)
		else $error("divide/root unit started while busy");

	a_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		dsu_sts.done |-> launched_q)
		else $error("unit finished without a launched operation");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_running_pearson_correlation.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_pearson_correlation: self-checking bench for the correlation block
// Feeds (x, y) pairs with random gaps and output stalls, predicts every result
// with a bit-accurate model of the fixed-point math and compares each field.
// ----------------------------------------------------------------------------
`default_nettype none

class corr_scoreboard;
	typedef struct packed {
		logic [16:0] cnt;
		logic [15:0] mx;
		logic [15:0] my;
		logic [14:0] dx;
		logic [14:0] dy;
		logic [15:0] r;
		logic [15:0] t;
		logic        ok;
		logic        sig;
	} stat_t;

	stat_t       pending[$];
	int          errors;
	logic [14:0] thresh;
	longint unsigned n, sxx, syy;
	longint      sx, sy, sxy;

	function new();
		errors = 0;
		thresh = 15'd502;
		n = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
	endfunction

	// floor(a * 2^k / d)
	function longint unsigned udiv_k(longint unsigned a, longint unsigned d, int k);
		longint unsigned q, rem;
		q = a / d;
		rem = a % d;
		return (q << k) + ((rem << k) / d);
	endfunction

	function longint sdiv_k(longint a, longint unsigned d, int k);
		longint unsigned q;
		q = udiv_k(a < 0 ? -a : a, d, k);
		return a < 0 ? -longint'(q) : longint'(q);
	endfunction

	function longint unsigned isqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function longint round_q12(longint m);
		longint unsigned mag;
		longint v;
		mag = ((m < 0 ? -m : m) + 128) >> 8;
		v = m < 0 ? -longint'(mag) : longint'(mag);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// accumulate one pair and queue its expected statistics
	function void note_pair(logic clr, logic signed [15:0] xi, logic signed [15:0] yi);
		longint x, y, mx, my, exy, cov, r, t;
		longint unsigned ex2, ey2, vx, vy, sdx, sdy, dox, doy, p, mag, rm, d, t2, tm;
		stat_t e;
		x = longint'(xi); y = longint'(yi); r = 0; t = 0;
		if (clr) begin
			n = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
		end
		if (n < 131071) begin
			n++; sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
		end
		mx = sdiv_k(sx, n, 8);
		my = sdiv_k(sy, n, 8);
		ex2 = udiv_k(sxx, n, 16);
		ey2 = udiv_k(syy, n, 16);
		exy = sdiv_k(sxy, n, 16);
		vx = ex2 > longint'(mx * mx) ? ex2 - mx * mx : 0;
		vy = ey2 > longint'(my * my) ? ey2 - my * my : 0;
		sdx = isqrt(vx);
		sdy = isqrt(vy);
		dox = (sdx + 128) >> 8;
		doy = (sdy + 128) >> 8;
		if (dox > 32767) dox = 32767;
		if (doy > 32767) doy = 32767;
		e.ok = n >= 3 && dox != 0 && doy != 0;
		if (e.ok) begin
			p = sdx * sdy;
			cov = exy - mx * my;
			mag = cov < 0 ? -cov : cov;
			rm = ((mag << 14) + p / 2) / p;
			if (rm > 16384) rm = 16384;
			r = cov < 0 ? -longint'(rm) : longint'(rm);
			if (rm >= 16384)
				tm = 32767;
			else begin
				d = (64'd1 << 28) - rm * rm;
				t2 = udiv_k(rm * rm * (n - 2), d, 16);
				tm = t2 >= 64'd1073676289 ? 32767 : isqrt(t2);
				if (tm > 32767) tm = 32767;
			end
			t = cov < 0 ? -longint'(tm) : longint'(tm);
		end
		e.cnt = n[16:0];
		e.mx = 16'(round_q12(mx));
		e.my = 16'(round_q12(my));
		e.dx = dox[14:0];
		e.dy = doy[14:0];
		e.r = r[15:0];
		e.t = t[15:0];
		e.sig = e.ok && (t < 0 ? -t : t) >= thresh;
		pending.push_back(e);
	endfunction

	function void check_result(stat_t got);
		stat_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e.cnt != got.cnt) report("sample_count", 64'(e.cnt), 64'(got.cnt));
		if (e.mx != got.mx) report("mean_x", 64'(e.mx), 64'(got.mx));
		if (e.my != got.my) report("mean_y", 64'(e.my), 64'(got.my));
		if (e.dx != got.dx) report("deviation_x", 64'(e.dx), 64'(got.dx));
		if (e.dy != got.dy) report("deviation_y", 64'(e.dy), 64'(got.dy));
		if (e.r != got.r) report("correlation", 64'(e.r), 64'(got.r));
		if (e.t != got.t) report("t_value", 64'(e.t), 64'(got.t));
		if (e.ok != got.ok) report("stats_valid", 64'(e.ok), 64'(got.ok));
		if (e.sig != got.sig) report("significant", 64'(e.sig), 64'(got.sig));
	endfunction

	function void report(string f, longint unsigned ev, longint unsigned av);
		$display("%0t: %s expected %h actual %h", $time, f, ev, av);
		errors++;
	endfunction
endclass

module tb_running_pearson_correlation;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0, arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
	logic command = 1'b0;
	logic signed [15:0] x_sample = '0, y_sample = '0;
	logic [16:0] sample_count;
	logic signed [15:0] mean_x, mean_y, correlation, t_value;
	logic [14:0] deviation_x, deviation_y;
	logic stats_valid, significant;
	logic calm = 1'b0;
	int idle_cycles = 0;
	corr_scoreboard sb;

	running_pearson_correlation dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// output side: random stalls, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result({sample_count, mean_x, mean_y, deviation_x, deviation_y,
					correlation, t_value, stats_valid, significant});
			out_stall <= !calm && ($urandom_range(99) < 16);
		end
	end

	// watchdog on cycles with no accepted item on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_running_pearson_correlation NOT OK");
				$finish;
			end
		end
	end

	// drive one item, drop valid once it is taken
	task automatic send_pair(logic clr, logic [15:0] xv, logic [15:0] yv);
		while (!calm && $urandom_range(99) < 16) @(posedge clk);
		in_valid <= 1'b1;
		command <= clr;
		x_sample <= xv;
		y_sample <= yv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_pair(clr, xv, yv);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_threshold(logic [14:0] v);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.thresh = v;
	endtask

	// random pair, mostly correlated so that r and t spread over their range
	task automatic send_random(logic clr);
		logic [15:0] xv, yv;
		int k;
		xv = 16'($urandom);
		k = int'($urandom_range(3));
		case (k)
			0: yv = 16'($urandom);
			1: yv = 16'(xv + $urandom_range(255));
			2: yv = 16'(-xv + $urandom_range(63));
			default: yv = 16'((xv >>> 3) + $urandom_range(4095));
		endcase
		send_pair(clr, xv, yv);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, constant data, perfect correlation, clears
		send_pair(1'b0, 16'h7fff, 16'h8000);
		send_pair(1'b0, 16'h8000, 16'h7fff);
		send_pair(1'b0, 16'h7fff, 16'h8000);
		send_pair(1'b0, 16'h0000, 16'hffff);
		send_pair(1'b1, 16'h1000, 16'h1000);
		send_pair(1'b0, 16'h1000, 16'h1000);
		send_pair(1'b0, 16'h1000, 16'h1000);
		send_pair(1'b1, 16'h1000, 16'h2000);
		send_pair(1'b0, 16'h2000, 16'h4000);
		send_pair(1'b0, 16'h3000, 16'h6000);
		send_pair(1'b0, 16'h4000, 16'h8000);
		send_pair(1'b1, 16'h0001, 16'h0002);
		send_pair(1'b0, 16'hffff, 16'h0000);
		send_pair(1'b0, 16'h0002, 16'h0001);
		send_pair(1'b0, 16'h0000, 16'h0003);
		for (int i = 0; i < 850; i++) begin
			if (i == 200) set_threshold(15'd0);
			if (i == 400) set_threshold(15'd32767);
			if (i == 600) set_threshold(15'(($urandom_range(3) + 1) * 300));
			calm = (i >= 300 && i < 380);
			send_random((i % 40 == 0) || ($urandom_range(99) < 3));
		end
		calm = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_running_pearson_correlation OK");
		else
			$display("tb_running_pearson_correlation NOT OK");
		$finish;
	end
endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/rpc_pkg.sv
hdl/rpc_dsu.sv
hdl/running_pearson_correlation.sv
dv/tb_running_pearson_correlation.sv
